FILE: design/aes_enc_pkg.sv
// Package for the AES block encryption unit: payload types, register
// indexes, S-box table and round helper functions. No dependencies.
package aes_enc_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } plain_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_t;

    localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd4;

    localparam logic [1:0] KEY_LEN_128 = 2'd0;
    localparam logic [1:0] KEY_LEN_192 = 2'd1;

    localparam int NUM_STAGES = 15;
    localparam int NUM_WORDS  = 60;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte b of the state sits at bits 127-8b; column-major layout
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                t[127 - 8 * (k + 4 * c) -: 8] = SBOX[s[127 - 8 * (k + 4 * ((c + k) % 4)) -: 8]];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] s;
        logic [7:0]   a0, a1, a2, a3;
        s = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32 * c -: 8];
            a1 = t[119 - 32 * c -: 8];
            a2 = t[111 - 32 * c -: 8];
            a3 = t[103 - 32 * c -: 8];
            s[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            s[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            s[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            s[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        mix_columns = s;
    endfunction

endpackage

FILE: design/aes_block_encrypt_unit.sv
// AES encryption top level: key expansion sequencer and unrolled round pipeline.
// Depends on aes_enc_pkg.
// Every key size uses all round stages (shorter keys pass through the spare round
// stages). Throughput: one request per cycle unless the result side stalls, set by
// the one-round-per-stage pipeline. After reset and after every configuration write
// the key expansion runs one word a cycle (4*Nr+4-Nk words, at most 52, after a load
// step) with requests stalled. Reset clears keys, length and pipeline valid bits.
module aes_block_encrypt_unit
    import aes_enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        plain_valid,
    output logic        plain_stall,
    input  plain_t      plain,
    output logic        cipher_valid,
    input  logic        cipher_stall,
    output cipher_t     cipher,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_reg [4];
    logic [1:0]  key_len_reg;
    logic        start_reg, busy_reg;
    logic [5:0]  gen_idx_reg, gen_last;
    logic [2:0]  gen_mod_reg;
    logic [7:0]  rcon_reg;
    logic [31:0] win_reg [8];
    logic [31:0] word_reg [NUM_WORDS];
    logic [31:0] temp, new_word, far_word;
    logic [3:0]  nk, nr;

    always_comb
    begin
        case (key_len_reg)
            KEY_LEN_128: nk = 4'd4;
            KEY_LEN_192: nk = 4'd6;
            default:     nk = 4'd8;
        endcase
        nr       = nk + 4'd6;
        gen_last = {nr, 2'b11};
    end

    always_comb
    begin
        case (key_len_reg)
            KEY_LEN_128: far_word = win_reg[4];
            KEY_LEN_192: far_word = win_reg[2];
            default:     far_word = win_reg[0];
        endcase
        temp = win_reg[7];
        if (gen_mod_reg == 3'd0)
            temp = sub_word({temp[23:0], temp[31:24]}) ^ {rcon_reg, 24'h0};
        else if (nk == 4'd8 && gen_mod_reg == 3'd4)
            temp = sub_word(temp);
        new_word = far_word ^ temp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
            key_len_reg <= KEY_LEN_128;
            start_reg   <= 1'b1;
            busy_reg    <= 1'b0;
            gen_idx_reg <= '0;
            gen_mod_reg <= '0;
            rcon_reg    <= 8'h01;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_WORD_0: key_reg[0] <= cfg_data;
                REG_KEY_WORD_1: key_reg[1] <= cfg_data;
                REG_KEY_WORD_2: key_reg[2] <= cfg_data;
                REG_KEY_WORD_3: key_reg[3] <= cfg_data;
                REG_KEY_LENGTH: key_len_reg <= cfg_data[1:0];
                default: ;
            endcase
            start_reg <= 1'b1;
            busy_reg  <= 1'b0;
        end
        else if (start_reg)
        begin
            start_reg   <= 1'b0;
            busy_reg    <= 1'b1;
            gen_idx_reg <= {2'b00, nk};
            gen_mod_reg <= '0;
            rcon_reg    <= 8'h01;
        end
        else if (busy_reg)
        begin
            gen_idx_reg <= gen_idx_reg + 6'd1;
            gen_mod_reg <= (gen_mod_reg == nk[2:0] - 3'd1 || (nk == 4'd8 && gen_mod_reg == 3'd7))
                           ? 3'd0 : gen_mod_reg + 3'd1;
            if (gen_mod_reg == 3'd0)
                rcon_reg <= xt(rcon_reg);
            if (gen_idx_reg == gen_last)
                busy_reg <= 1'b0;
        end
    end

    // expanded key words and sliding window of the last eight words
    always_ff @(posedge clk)
    begin
        if (start_reg && !cfg_we)
        begin
            for (int j = 0; j < 4; j++)
            begin
                word_reg[2 * j]     <= key_reg[j][63:32];
                word_reg[2 * j + 1] <= key_reg[j][31:0];
            end
            for (int j = 0; j < 8; j++)
                win_reg[j] <= '0;
            case (key_len_reg)
                KEY_LEN_128:
                begin
                    win_reg[4] <= key_reg[0][63:32];
                    win_reg[5] <= key_reg[0][31:0];
                    win_reg[6] <= key_reg[1][63:32];
                    win_reg[7] <= key_reg[1][31:0];
                end
                KEY_LEN_192:
                begin
                    win_reg[2] <= key_reg[0][63:32];
                    win_reg[3] <= key_reg[0][31:0];
                    win_reg[4] <= key_reg[1][63:32];
                    win_reg[5] <= key_reg[1][31:0];
                    win_reg[6] <= key_reg[2][63:32];
                    win_reg[7] <= key_reg[2][31:0];
                end
                default:
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        win_reg[2 * j]     <= key_reg[j][63:32];
                        win_reg[2 * j + 1] <= key_reg[j][31:0];
                    end
                end
            endcase
        end
        else if (busy_reg && !cfg_we)
        begin
            word_reg[gen_idx_reg] <= new_word;
            for (int j = 0; j < 7; j++)
                win_reg[j] <= win_reg[j + 1];
            win_reg[7] <= new_word;
        end
    end

    // round pipeline: stage 0 is the initial key add, stage r is round r
    logic [127:0] st_reg [NUM_STAGES];
    logic         v_reg  [NUM_STAGES];
    logic         adv    [NUM_STAGES];
    logic [127:0] st_next [NUM_STAGES];

    always_comb
    begin
        adv[NUM_STAGES - 1] = !v_reg[NUM_STAGES - 1] || !cipher_stall;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
            adv[s] = !v_reg[s] || adv[s + 1];
    end

    assign plain_stall = !adv[0] || busy_reg || start_reg;

    always_comb
    begin
        logic [127:0] t;
        st_next[0] = plain ^ {word_reg[0], word_reg[1], word_reg[2], word_reg[3]};
        for (int r = 1; r < NUM_STAGES; r++)
        begin
            t = sub_shift(st_reg[r - 1]);
            if (4'(r) < nr)
                t = mix_columns(t);
            if (4'(r) <= nr)
                st_next[r] = t ^ {word_reg[4 * r], word_reg[4 * r + 1],
                                  word_reg[4 * r + 2], word_reg[4 * r + 3]};
            else
                st_next[r] = st_reg[r - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
                v_reg[s] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= plain_valid && !plain_stall;
            for (int s = 1; s < NUM_STAGES; s++)
                if (adv[s])
                    v_reg[s] <= v_reg[s - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NUM_STAGES; s++)
            if (adv[s])
                st_reg[s] <= st_next[s];
    end

    assign cipher_valid = v_reg[NUM_STAGES - 1];
    assign cipher       = st_reg[NUM_STAGES - 1];

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg || start_reg) |-> plain_stall)
        else $error("request taken during key expansion");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> start_reg)
        else $error("configuration write did not restart key expansion");

    a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (gen_idx_reg <= gen_last && gen_idx_reg >= {2'b00, nk}))
        else $error("key expansion index out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !adv[0]) |=> v_reg[0])
        else $error("first stage dropped a stalled request");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for aes_block_encrypt_unit: directed known-answer rows, then
// random requests under random keys of every length, checked by a local AES predictor.
// Depends on aes_enc_pkg and the RTL top level.
module tb_top;
    import aes_enc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KEY_LEN_256 = 2'd2;
    localparam logic [1:0] KEY_LEN_ALT = 2'd3;   // decodes as 256 bits
    localparam logic [2:0] REG_SPARE_5 = 3'd5;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam int LATENCY     = 15;
    localparam int STALL_LIMIT = 4000;
    localparam int NUM_RANDOM  = 1450;
    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        plain_valid = 1'b0;
    logic        plain_stall;
    plain_t      plain = '0;
    logic        cipher_valid;
    logic        cipher_stall = 1'b0;
    cipher_t     cipher;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    aes_block_encrypt_unit dut (.*);

    always #5 clk = ~clk;

    // local copy of the key registers and the S-box
    logic [63:0] key_regs [4];
    logic [1:0]  key_len;
    logic [7:0]  sb [256];

    cipher_t expected_blocks [$];
    int errors = 0;
    int n_blocks = 0;
    int n_cfg = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    typedef struct {
        bit          wr;
        logic [1:0]  len;
        logic [63:0] k0, k1, k2, k3;
        plain_t      p;
        bit          known;
        cipher_t     ct;
    } kat_row_t;

    function automatic logic [7:0] dbl(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    task automatic build_sbox();
        logic [7:0] inv, base, v;
        int e;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'd1;
            base = x[7:0];
            e = 254;
            while (e != 0)
            begin
                if (e[0]) inv = gf_mul(inv, base);
                base = gf_mul(base, base);
                e = e >> 1;
            end
            if (x == 0) inv = 8'd0;
            v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb[x] = v;
        end
    endtask

    function automatic cipher_t aes_encrypt(plain_t p);
        logic [7:0] ek [240];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] w [4];
        logic [7:0] f, rc, a0, a1, a2, a3;
        logic [127:0] blk;
        int nk, nr, total;
        cipher_t r;
        nk = (key_len == KEY_LEN_128) ? 4 : (key_len == KEY_LEN_192) ? 6 : 8;
        nr = nk + 6;
        total = 4 * (nr + 1);
        rc = 8'h01;
        for (int i = 0; i < 4 * nk; i++)
            ek[i] = key_regs[i / 8][63 - 8 * (i % 8) -: 8];
        for (int i = nk; i < total; i++)
        begin
            for (int k = 0; k < 4; k++) w[k] = ek[4 * (i - 1) + k];
            if (i % nk == 0)
            begin
                f = w[0];
                w[0] = sb[w[1]] ^ rc;
                w[1] = sb[w[2]];
                w[2] = sb[w[3]];
                w[3] = sb[f];
                rc = dbl(rc);
            end
            else if (nk > 6 && i % nk == 4)
            begin
                for (int k = 0; k < 4; k++) w[k] = sb[w[k]];
            end
            for (int k = 0; k < 4; k++) ek[4 * i + k] = ek[4 * (i - nk) + k] ^ w[k];
        end
        blk = {p.plain_high, p.plain_low};
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ ek[i];
        for (int rnd = 1; rnd <= nr; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++)
                    t[k + 4 * c] = sb[s[k + 4 * ((c + k) % 4)]];
            if (rnd != nr)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    s[4 * c]     = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    s[4 * c + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    s[4 * c + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    s[4 * c + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end
            else
            begin
                for (int i = 0; i < 16; i++) s[i] = t[i];
            end
            for (int i = 0; i < 16; i++) s[i] ^= ek[16 * rnd + i];
        end
        for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = s[i];
        r.cipher_high = blk[127:64];
        r.cipher_low  = blk[63:0];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report(string what, cipher_t got, cipher_t want);
        errors++;
        $display("MISMATCH %s: got %h_%h want %h_%h", what,
                 got.cipher_high, got.cipher_low, want.cipher_high, want.cipher_low);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KEY_WORD_0: key_regs[0] = data;
            REG_KEY_WORD_1: key_regs[1] = data;
            REG_KEY_WORD_2: key_regs[2] = data;
            REG_KEY_WORD_3: key_regs[3] = data;
            REG_KEY_LENGTH: key_len = data[1:0];
            default: ;   // unmapped index, ignored
        endcase
        n_cfg++;
    endtask

    // pipeline must be empty before the key changes; no request held while waiting
    task automatic drain();
        @(negedge clk);
        plain_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic load_key(logic [1:0] len, logic [63:0] k0, logic [63:0] k1,
                            logic [63:0] k2, logic [63:0] k3);
        drain();
        write_reg(REG_KEY_WORD_0, k0);
        write_reg(REG_KEY_WORD_1, k1);
        write_reg(REG_KEY_WORD_2, k2);
        write_reg(REG_KEY_WORD_3, k3);
        if ($urandom_range(0, 2) == 0)
            write_reg(3'($urandom_range(REG_SPARE_5, REG_SPARE_7)), rand64());
        write_reg(REG_KEY_LENGTH, {62'd0, len});
    endtask

    task automatic send(plain_t p, bit known, cipher_t ct);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        repeat (gap)
        begin
            @(negedge clk);
            plain_valid <= 1'b0;
        end
        @(negedge clk);
        plain_valid <= 1'b1;
        plain <= p;
        do @(posedge clk); while (plain_stall);
        expected_blocks.push_back(known ? ct : aes_encrypt(p));
    endtask

    // result side: random stall before each result
    initial
    begin
        int n;
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 14);
            repeat (n)
            begin
                @(negedge clk);
                cipher_stall <= 1'b1;
            end
            @(negedge clk);
            cipher_stall <= 1'b0;
            do @(posedge clk); while (!cipher_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((plain_valid && !plain_stall) || (cipher_valid && !cipher_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (rst_n && cipher_valid && !cipher_stall)
        begin
            if (expected_blocks.size() == 0)
            begin
                errors++;
                $display("UNEXPECTED ciphertext %h_%h", cipher.cipher_high, cipher.cipher_low);
            end
            else
            begin
                cipher_t want;
                want = expected_blocks.pop_front();
                if (cipher.cipher_high !== want.cipher_high)
                    report("cipher_high", cipher, want);
                else if (cipher.cipher_low !== want.cipher_low)
                    report("cipher_low", cipher, want);
                n_blocks++;
            end
        end
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        kat_row_t rows [$];
        kat_row_t r;
        logic [63:0] k128_0, k128_1, k192_2, k256_2, k256_3;
        plain_t fips_pt;
        k128_0 = 64'h0001020304050607;
        k128_1 = 64'h08090a0b0c0d0e0f;
        k192_2 = 64'h1011121314151617;
        k256_2 = 64'h1011121314151617;
        k256_3 = 64'h18191a1b1c1d1e1f;
        fips_pt = '{64'h0011223344556677, 64'h8899aabbccddeeff};
        key_regs = '{default: '0};
        key_len = KEY_LEN_128;
        build_sbox();

        // state after reset, no writes: all-zero 128-bit key
        rows.push_back('{0, 0, 0, 0, 0, 0, '0, 1,
                         '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}});
        rows.push_back('{0, 0, 0, 0, 0, 0, '{ONES, ONES}, 0, '0});
        rows.push_back('{1, KEY_LEN_128, k128_0, k128_1, 0, 0, fips_pt, 1,
                         '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}});
        // unused words full of ones must not matter
        rows.push_back('{1, KEY_LEN_128, k128_0, k128_1, ONES, ONES, fips_pt, 1,
                         '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}});
        rows.push_back('{1, KEY_LEN_128, ONES, ONES, ONES, ONES, '{ONES, ONES}, 0, '0});
        rows.push_back('{1, KEY_LEN_192, k128_0, k128_1, k192_2, ONES, fips_pt, 1,
                         '{64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191}});
        rows.push_back('{0, 0, 0, 0, 0, 0, '0, 0, '0});
        rows.push_back('{1, KEY_LEN_192, ONES, ONES, ONES, 0, '{ONES, 0}, 0, '0});
        rows.push_back('{1, KEY_LEN_256, k128_0, k128_1, k256_2, k256_3, fips_pt, 1,
                         '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}});
        // length code 3 behaves as a 256-bit key
        rows.push_back('{1, KEY_LEN_ALT, k128_0, k128_1, k256_2, k256_3, fips_pt, 1,
                         '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}});
        rows.push_back('{1, KEY_LEN_256, ONES, ONES, ONES, ONES, '0, 0, '0});
        rows.push_back('{0, 0, 0, 0, 0, 0, '{0, ONES}, 0, '0});
        rows.push_back('{1, KEY_LEN_256, 0, 0, 0, 0, '{ONES, ONES}, 0, '0});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.wr) load_key(r.len, r.k0, r.k1, r.k2, r.k3);
            calm = (i % 4 == 3);
            send(r.p, r.known, r.ct);
        end

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 120 == 0)
            begin
                @(negedge clk);
                plain_valid <= 1'b0;
                load_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
            end
            if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            send('{rand64(), rand64()}, 1'b0, '0);
        end
        @(negedge clk);
        plain_valid <= 1'b0;
        drain();

        $display("Encrypted %0d blocks across %0d register writes, keys of all lengths",
                 n_blocks, n_cfg);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
design/aes_enc_pkg.sv
design/aes_block_encrypt_unit.sv
dv/tb_top.sv
